### sv/rlpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RLE pattern decoder package
// Shared types, status codes, character codes and limits of the decoder.
// ----------------------------------------------------------------------------
package rlpd_pkg;

  // Largest pattern dimension; registers above it are clamped
  localparam logic [12:0] MAX_DIM = 13'd4096;

  // Largest run count that may be built from digits
  localparam logic [30:0] COUNT_LIMIT = 31'h7FFF_FFFF;

  // Configuration register indexes
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  // Reset value of both dimension registers
  localparam logic [12:0] DIM_RESET = 13'd64;

  // Body characters
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_DEAD   = 8'h62;
  localparam logic [7:0] CH_LIVE   = 8'h6F;
  localparam logic [7:0] CH_ROW    = 8'h24;
  localparam logic [7:0] CH_END    = 8'h21;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [3:0] {
    ST_CONSUMED    = 4'd0,
    ST_DONE        = 4'd1,
    ST_RUN_BIG     = 4'd2,
    ST_WIDTH       = 4'd3,
    ST_LIVE_HEIGHT = 4'd4,
    ST_ROWS_HEIGHT = 4'd5,
    ST_COUNT_END   = 4'd6,
    ST_BAD_TOKEN   = 4'd7,
    ST_NO_END      = 4'd8,
    ST_FINISHED    = 4'd9
  } status_t;

  typedef enum logic [1:0] {
    FS_ACTIVE = 2'd0,
    FS_DONE   = 2'd1,
    FS_FAILED = 2'd2
  } finish_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_body;
    logic       start_pattern;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic        run_valid;
    logic [11:0] run_x;
    logic [11:0] run_y;
    logic [12:0] run_length;
  } out_item_t;

  // Declared pattern dimensions as written
  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
  } dims_t;

endpackage

### sv/rle_life_pattern_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RLE Life pattern body decoder
// Decodes a pattern body one character per request into live run descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   The in channel (in_valid / in_ready / in_item) carries one body character
//   or an end-of-body mark per request; start_pattern restarts the decoder.
//   The out channel (out_valid / out_ready / out_item) returns exactly one
//   result per request: a status code and, for a live run, its start column,
//   row and length.
//   A request passes from the input register through the single decode stage
//   into the result register; one request is taken every cycle while the
//   result is taken (out_ready high) or the result register is empty.
//   pattern_width and pattern_height are written through cfg_wen, cfg_index and
//   cfg_data, by the user only while idle (not enforced); both reset to 64.
//   Reset empties both registers, clears the cursor, count and finish state.
//   When out_ready is low the result holds, the input register fills, and
//   in_ready then drops until the result is taken.
// ----------------------------------------------------------------------------
module rle_life_pattern_decoder_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rlpd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rlpd_pkg::out_item_t out_item,
  input  logic                cfg_wen,
  input  logic                cfg_index,
  input  logic [12:0]         cfg_data
);

  logic                s1_valid;
  rlpd_pkg::in_item_t  s1_item;
  logic                s1_move;
  rlpd_pkg::out_item_t result;
  rlpd_pkg::dims_t     dims;

  // Move the held request into the result register when there is room
  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;

  // Hold the dimension registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dims.width  <= rlpd_pkg::DIM_RESET;
      dims.height <= rlpd_pkg::DIM_RESET;
    end else if (cfg_wen) begin
      if (cfg_index == rlpd_pkg::CFG_IDX_WIDTH) begin
        dims.width <= cfg_data;
      end
      if (cfg_index == rlpd_pkg::CFG_IDX_HEIGHT) begin
        dims.height <= cfg_data;
      end
    end
  end

  // Input and result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
    if (s1_move) begin
      out_item <= result;
    end
  end

  rlpd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_move),
    .item   (s1_item),
    .dims   (dims),
    .result (result)
  );

endmodule

### sv/rlpd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RLE pattern decoder core
// Holds the cursor, run count and finish state and decodes one request.
// ----------------------------------------------------------------------------
module rlpd_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  rlpd_pkg::in_item_t  item,
  input  rlpd_pkg::dims_t     dims,
  output rlpd_pkg::out_item_t result
);

  logic [12:0]       cursor_column, cursor_column_next;
  logic [12:0]       cursor_row, cursor_row_next;
  logic [30:0]       pending_count, pending_count_next;
  rlpd_pkg::finish_t finish_state, finish_state_next;
  rlpd_pkg::status_t error_code, error_code_next;

  // State as seen after an optional start of pattern
  logic [12:0]       col_e, row_e;
  logic [30:0]       pend_e;
  rlpd_pkg::finish_t fs_e;
  rlpd_pkg::status_t err_e;

  logic [12:0] w, h;
  logic [3:0]  digit_diff;
  logic [34:0] count_mul;
  logic        count_big;
  logic [30:0] run;
  logic [31:0] col_sum, row_sum;
  logic        is_blank, is_digit;
  logic [7:0]  c;

  // Clamp the declared dimensions
  assign w = (dims.width  > rlpd_pkg::MAX_DIM) ? rlpd_pkg::MAX_DIM : dims.width;
  assign h = (dims.height > rlpd_pkg::MAX_DIM) ? rlpd_pkg::MAX_DIM : dims.height;

  // Apply start of pattern before the character
  assign col_e  = item.start_pattern ? 13'd0 : cursor_column;
  assign row_e  = item.start_pattern ? 13'd0 : cursor_row;
  assign pend_e = item.start_pattern ? 31'd0 : pending_count;
  assign fs_e   = item.start_pattern ? rlpd_pkg::FS_ACTIVE : finish_state;
  assign err_e  = item.start_pattern ? rlpd_pkg::ST_CONSUMED : error_code;

  // Classify the character
  assign c        = item.char_code;
  assign is_blank = (c == rlpd_pkg::CH_SPACE) ||
                    ((c >= rlpd_pkg::CH_TAB) && (c <= rlpd_pkg::CH_CR));
  assign is_digit = (c >= rlpd_pkg::CH_ZERO) && (c <= rlpd_pkg::CH_NINE);

  // Next count is ten times the count plus the digit
  assign digit_diff = 4'(c - rlpd_pkg::CH_ZERO);
  assign count_mul  = {1'b0, pend_e, 3'b000} + {3'b000, pend_e, 1'b0}
                    + {31'd0, digit_diff};
  assign count_big  = count_mul > {4'd0, rlpd_pkg::COUNT_LIMIT};

  // Run defaults to one without a count
  assign run     = (pend_e == 31'd0) ? 31'd1 : pend_e;
  assign col_sum = {19'd0, col_e} + {1'b0, run};
  assign row_sum = {19'd0, row_e} + {1'b0, run};

  // Decode one character
  always_comb begin
    cursor_column_next = col_e;
    cursor_row_next    = row_e;
    pending_count_next = pend_e;
    finish_state_next  = fs_e;
    error_code_next    = err_e;
    result             = '0;
    result.status      = rlpd_pkg::ST_CONSUMED;
    priority if (fs_e == rlpd_pkg::FS_FAILED) begin
      result.status = err_e;
    end else if (fs_e == rlpd_pkg::FS_DONE) begin
      result.status = rlpd_pkg::ST_FINISHED;
    end else if (item.end_of_body) begin
      finish_state_next = rlpd_pkg::FS_FAILED;
      error_code_next   = rlpd_pkg::ST_NO_END;
      result.status     = rlpd_pkg::ST_NO_END;
    end else if (is_blank) begin
      result.status = rlpd_pkg::ST_CONSUMED;
    end else if (is_digit) begin
      if (count_big) begin
        finish_state_next = rlpd_pkg::FS_FAILED;
        error_code_next   = rlpd_pkg::ST_RUN_BIG;
        result.status     = rlpd_pkg::ST_RUN_BIG;
      end else begin
        pending_count_next = count_mul[30:0];
      end
    end else if ((c == rlpd_pkg::CH_DEAD) || (c == rlpd_pkg::CH_LIVE)) begin
      pending_count_next = 31'd0;
      if (col_sum > {19'd0, w}) begin
        finish_state_next = rlpd_pkg::FS_FAILED;
        error_code_next   = rlpd_pkg::ST_WIDTH;
        result.status     = rlpd_pkg::ST_WIDTH;
      end else if ((c == rlpd_pkg::CH_LIVE) && (row_e >= h)) begin
        finish_state_next = rlpd_pkg::FS_FAILED;
        error_code_next   = rlpd_pkg::ST_LIVE_HEIGHT;
        result.status     = rlpd_pkg::ST_LIVE_HEIGHT;
      end else begin
        if (c == rlpd_pkg::CH_LIVE) begin
          result.run_valid  = 1'b1;
          result.run_x      = col_e[11:0];
          result.run_y      = row_e[11:0];
          result.run_length = run[12:0];
        end
        cursor_column_next = col_sum[12:0];
      end
    end else if (c == rlpd_pkg::CH_ROW) begin
      pending_count_next = 31'd0;
      cursor_column_next = 13'd0;
      if (row_sum > {19'd0, h}) begin
        finish_state_next = rlpd_pkg::FS_FAILED;
        error_code_next   = rlpd_pkg::ST_ROWS_HEIGHT;
        result.status     = rlpd_pkg::ST_ROWS_HEIGHT;
      end else begin
        cursor_row_next = row_sum[12:0];
      end
    end else if (c == rlpd_pkg::CH_END) begin
      if (pend_e != 31'd0) begin
        finish_state_next = rlpd_pkg::FS_FAILED;
        error_code_next   = rlpd_pkg::ST_COUNT_END;
        result.status     = rlpd_pkg::ST_COUNT_END;
      end else begin
        finish_state_next = rlpd_pkg::FS_DONE;
        result.status     = rlpd_pkg::ST_DONE;
      end
    end else begin
      finish_state_next = rlpd_pkg::FS_FAILED;
      error_code_next   = rlpd_pkg::ST_BAD_TOKEN;
      result.status     = rlpd_pkg::ST_BAD_TOKEN;
    end
  end

  // Advance the state on each decoded request
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= 13'd0;
      cursor_row    <= 13'd0;
      pending_count <= 31'd0;
      finish_state  <= rlpd_pkg::FS_ACTIVE;
      error_code    <= rlpd_pkg::ST_CONSUMED;
    end else if (step) begin
      cursor_column <= cursor_column_next;
      cursor_row    <= cursor_row_next;
      pending_count <= pending_count_next;
      finish_state  <= finish_state_next;
      error_code    <= error_code_next;
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RLE Life pattern decoder testbench
// Drives pattern bodies, directed first and then random, through the decoder.
// Each accepted request is decoded by a local model and the expected answer
// is queued. Every returned answer is compared field by field with the
// oldest queued one. The dimension registers are changed between phases
// while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [7:0] BAD_CHAR = 8'h71;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  rlpd_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  rlpd_pkg::out_item_t out_item;
  logic                cfg_wen = 1'b0;
  logic                cfg_index = 1'b0;
  logic [12:0]         cfg_data = '0;

  // Requests waiting to be sent and answers waiting to arrive
  rlpd_pkg::in_item_t  char_queue[$];
  rlpd_pkg::out_item_t expected_answers[$];
  int unsigned queued_total = 0;
  int unsigned fault_count = 0;
  bit          req_taken = 1'b0;
  bit          open_flag = 1'b0;
  int unsigned send_idle_pct = 26;
  int unsigned recv_stall_pct = 47;

  // Decoder model state
  logic [12:0]       dim_width = rlpd_pkg::DIM_RESET;
  logic [12:0]       dim_height = rlpd_pkg::DIM_RESET;
  longint unsigned   col_pos = 0;
  longint unsigned   row_pos = 0;
  longint unsigned   run_count = 0;
  rlpd_pkg::finish_t fin_state = rlpd_pkg::FS_ACTIVE;
  rlpd_pkg::status_t fail_code = rlpd_pkg::ST_CONSUMED;

  rle_life_pattern_decoder_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decode one request and advance the model state
  function automatic rlpd_pkg::out_item_t decode_char(rlpd_pkg::in_item_t req);
    rlpd_pkg::out_item_t res;
    longint unsigned     w, h, run, digit, next_row;
    res = '0;
    res.status = rlpd_pkg::ST_CONSUMED;
    w = (dim_width > rlpd_pkg::MAX_DIM) ? rlpd_pkg::MAX_DIM : dim_width;
    h = (dim_height > rlpd_pkg::MAX_DIM) ? rlpd_pkg::MAX_DIM : dim_height;
    if (req.start_pattern) begin
      col_pos = 0;
      row_pos = 0;
      run_count = 0;
      fin_state = rlpd_pkg::FS_ACTIVE;
      fail_code = rlpd_pkg::ST_CONSUMED;
    end
    if (fin_state == rlpd_pkg::FS_FAILED) begin
      res.status = fail_code;
    end else if (fin_state == rlpd_pkg::FS_DONE) begin
      res.status = rlpd_pkg::ST_FINISHED;
    end else if (req.end_of_body) begin
      res.status = rlpd_pkg::ST_NO_END;
    end else if (req.char_code == rlpd_pkg::CH_SPACE ||
                 (req.char_code >= rlpd_pkg::CH_TAB &&
                  req.char_code <= rlpd_pkg::CH_CR)) begin
      res.status = rlpd_pkg::ST_CONSUMED;
    end else if (req.char_code >= rlpd_pkg::CH_ZERO &&
                 req.char_code <= rlpd_pkg::CH_NINE) begin
      digit = req.char_code - rlpd_pkg::CH_ZERO;
      if (run_count > (longint'(rlpd_pkg::COUNT_LIMIT) - digit) / 10)
        res.status = rlpd_pkg::ST_RUN_BIG;
      else
        run_count = run_count * 10 + digit;
    end else if (req.char_code == rlpd_pkg::CH_DEAD ||
                 req.char_code == rlpd_pkg::CH_LIVE) begin
      run = (run_count == 0) ? 1 : run_count;
      run_count = 0;
      if (col_pos + run > w) begin
        res.status = rlpd_pkg::ST_WIDTH;
      end else if (req.char_code == rlpd_pkg::CH_LIVE && row_pos >= h) begin
        res.status = rlpd_pkg::ST_LIVE_HEIGHT;
      end else begin
        if (req.char_code == rlpd_pkg::CH_LIVE) begin
          res.run_valid = 1'b1;
          res.run_x = 12'(col_pos);
          res.run_y = 12'(row_pos);
          res.run_length = 13'(run);
        end
        col_pos = col_pos + run;
      end
    end else if (req.char_code == rlpd_pkg::CH_ROW) begin
      run = (run_count == 0) ? 1 : run_count;
      run_count = 0;
      next_row = row_pos + run;
      col_pos = 0;
      if (next_row > h)
        res.status = rlpd_pkg::ST_ROWS_HEIGHT;
      else
        row_pos = next_row;
    end else if (req.char_code == rlpd_pkg::CH_END) begin
      res.status = (run_count != 0) ? rlpd_pkg::ST_COUNT_END : rlpd_pkg::ST_DONE;
    end else begin
      res.status = rlpd_pkg::ST_BAD_TOKEN;
    end
    // Latch the finish state: done, or failed with a sticky code
    if (fin_state == rlpd_pkg::FS_ACTIVE) begin
      if (res.status == rlpd_pkg::ST_DONE) begin
        fin_state = rlpd_pkg::FS_DONE;
      end else if (res.status != rlpd_pkg::ST_CONSUMED) begin
        fin_state = rlpd_pkg::FS_FAILED;
        fail_code = res.status;
      end
    end
    return res;
  endfunction

  task automatic note_fault(input string what, input rlpd_pkg::out_item_t want,
                            input rlpd_pkg::out_item_t got);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t: %s: expected st=%0d v=%0b x=%0d y=%0d len=%0d, got st=%0d v=%0b x=%0d y=%0d len=%0d",
               $time, what, want.status, want.run_valid, want.run_x, want.run_y,
               want.run_length, got.status, got.run_valid, got.run_x, got.run_y,
               got.run_length);
  endtask

  // Present requests at the falling edge; hold each until it is taken
  always @(negedge clk) begin : drive_requests
    rlpd_pkg::in_item_t nxt_item;
    logic               nxt_valid;
    nxt_item = in_item;
    nxt_valid = in_valid;
    if (!rst) begin
      if (!in_valid || req_taken) begin
        if (char_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt_item = char_queue.pop_front();
          nxt_valid = 1'b1;
        end else begin
          nxt_valid = 1'b0;
        end
      end
      req_taken = 1'b0;
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
    in_valid <= nxt_valid;
    in_item <= nxt_item;
  end

  // Predict on each accepted request, check each accepted answer
  always @(posedge clk) begin : watch_ports
    rlpd_pkg::out_item_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_answers.insert(expected_answers.size(), decode_char(in_item));
        req_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          note_fault("unexpected answer", '0, out_item);
        end else begin
          want = expected_answers.pop_front();
          if (want.status !== out_item.status || want.run_valid !== out_item.run_valid ||
              want.run_x !== out_item.run_x || want.run_y !== out_item.run_y ||
              want.run_length !== out_item.run_length)
            note_fault("answer mismatch", want, out_item);
        end
      end
    end
  end

  task automatic push_req(input logic [7:0] ch, input logic eob, input logic restart);
    rlpd_pkg::in_item_t r;
    r.char_code = ch;
    r.end_of_body = eob;
    r.start_pattern = restart;
    char_queue.insert(char_queue.size(), r);
    queued_total++;
  endtask

  // Push a body character; the first one after open_flag restarts the pattern
  task automatic push_char(input logic [7:0] ch);
    push_req(ch, 1'b0, open_flag);
    open_flag = 1'b0;
  endtask

  task automatic push_count(input int unsigned n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i]);
  endtask

  task automatic maybe_blank();
    if ($urandom_range(7) == 0)
      push_char(($urandom_range(5) == 0) ? rlpd_pkg::CH_SPACE :
                8'(rlpd_pkg::CH_TAB + $urandom_range(4)));
  endtask

  // Build a mostly well-formed body sized to the current dimensions
  task automatic build_pattern();
    int unsigned w, h, col, row, run, room, step, rows;
    logic [7:0]  mark;
    w = (dim_width > rlpd_pkg::MAX_DIM) ? rlpd_pkg::MAX_DIM : dim_width;
    h = (dim_height > rlpd_pkg::MAX_DIM) ? rlpd_pkg::MAX_DIM : dim_height;
    open_flag = 1'b1;
    if ($urandom_range(3) == 0)
      push_char(rlpd_pkg::CH_SPACE);
    rows = $urandom_range(1, 5);
    row = 0;
    for (int r = 0; r < rows; r++) begin
      col = 0;
      repeat ($urandom_range(1, 6)) begin
        room = (w > col) ? w - col : 0;
        case ($urandom_range(19))
          0:       run = room + 1;
          1, 2:    run = (room == 0) ? 1 : room;
          default: run = (room == 0) ? 1 : $urandom_range(1, (room < 9) ? room : 9);
        endcase
        mark = $urandom_range(1) ? rlpd_pkg::CH_LIVE : rlpd_pkg::CH_DEAD;
        if (run > 1 || $urandom_range(5) == 0)
          push_count(run);
        push_char(mark);
        maybe_blank();
        col += run;
      end
      if (r + 1 < rows) begin
        case ($urandom_range(9))
          0:       step = (h > row) ? h - row : 1;
          1, 2:    step = $urandom_range(2, 3);
          default: step = 1;
        endcase
        if (step > 1 || $urandom_range(5) == 0)
          push_count(step);
        push_char(rlpd_pkg::CH_ROW);
        maybe_blank();
        row += step;
      end
    end
    // Close the body: terminator mostly, sometimes missing or after a count
    case ($urandom_range(15))
      0: push_req(8'($urandom_range(255)), 1'b1, 1'b0);
      1: begin
        push_count($urandom_range(1, 9));
        push_char(rlpd_pkg::CH_END);
      end
      default: push_char(rlpd_pkg::CH_END);
    endcase
    if ($urandom_range(4) == 0)
      push_req(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
  endtask

  // Random bytes, oversized counts and count edge cases
  task automatic build_noise();
    case ($urandom_range(3))
      0: repeat ($urandom_range(1, 4))
        push_req(8'($urandom_range(255)), $urandom_range(3) == 0, $urandom_range(3) == 0);
      1: begin
        open_flag = 1'b1;
        push_count($urandom_range(1, 9));
        repeat ($urandom_range(9, 11))
          push_char(8'(rlpd_pkg::CH_ZERO + $urandom_range(9)));
        push_char(rlpd_pkg::CH_LIVE);
      end
      2: begin
        // one digit short of the count limit, the last digit decides
        open_flag = 1'b1;
        push_count(214748364);
        push_char(8'(rlpd_pkg::CH_ZERO + $urandom_range(9)));
        push_char(rlpd_pkg::CH_END);
      end
      default: begin
        open_flag = 1'b1;
        push_char(rlpd_pkg::CH_ZERO);
        push_char(rlpd_pkg::CH_LIVE);
        push_char(rlpd_pkg::CH_END);
      end
    endcase
  endtask

  task automatic queue_random_bodies(input int unsigned n);
    int unsigned target;
    target = queued_total + n;
    while (queued_total < target) begin
      if ($urandom_range(4) == 0)
        build_noise();
      else
        build_pattern();
    end
  endtask

  // Hold until every request is sent and every answer has arrived
  task automatic settle();
    while (char_queue.size() != 0 || in_valid || expected_answers.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_dim(input logic idx, input logic [12:0] val);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    if (idx == rlpd_pkg::CFG_IDX_WIDTH)
      dim_width = val;
    else
      dim_height = val;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed body at the reset dimensions of 64 by 64
    push_req(rlpd_pkg::CH_SPACE, 1'b0, 1'b1);
    push_req(rlpd_pkg::CH_TAB, 1'b0, 1'b0);
    push_req(rlpd_pkg::CH_CR, 1'b0, 1'b0);
    push_req(8'(rlpd_pkg::CH_ZERO + 3), 1'b0, 1'b0);
    push_req(rlpd_pkg::CH_LIVE, 1'b0, 1'b0);
    push_req(rlpd_pkg::CH_DEAD, 1'b0, 1'b0);
    push_req(rlpd_pkg::CH_LIVE, 1'b0, 1'b0);
    push_req(8'(rlpd_pkg::CH_ZERO + 2), 1'b0, 1'b0);
    push_req(rlpd_pkg::CH_ROW, 1'b0, 1'b0);
    // fill a whole row, then overrun it and stay failed
    push_req(8'(rlpd_pkg::CH_ZERO + 6), 1'b0, 1'b0);
    push_req(8'(rlpd_pkg::CH_ZERO + 4), 1'b0, 1'b0);
    push_req(rlpd_pkg::CH_LIVE, 1'b0, 1'b0);
    push_req(rlpd_pkg::CH_LIVE, 1'b0, 1'b0);
    push_req(8'hFF, 1'b1, 1'b0);
    // done, then anything after it
    push_req(rlpd_pkg::CH_END, 1'b0, 1'b1);
    push_req(8'hFF, 1'b0, 1'b0);
    // count left before the terminator
    push_req(8'(rlpd_pkg::CH_ZERO + 5), 1'b0, 1'b1);
    push_req(rlpd_pkg::CH_END, 1'b0, 1'b0);
    // unknown character; end of body beats a character
    push_req(BAD_CHAR, 1'b0, 1'b1);
    push_req(rlpd_pkg::CH_LIVE, 1'b1, 1'b1);
    // live run below the last row, then too many rows
    push_req(8'(rlpd_pkg::CH_ZERO + 6), 1'b0, 1'b1);
    push_req(8'(rlpd_pkg::CH_ZERO + 4), 1'b0, 1'b0);
    push_req(rlpd_pkg::CH_ROW, 1'b0, 1'b0);
    push_req(rlpd_pkg::CH_LIVE, 1'b0, 1'b0);
    push_req(8'(rlpd_pkg::CH_ZERO + 6), 1'b0, 1'b1);
    push_req(8'(rlpd_pkg::CH_ZERO + 5), 1'b0, 1'b0);
    push_req(rlpd_pkg::CH_ROW, 1'b0, 1'b0);
    queue_random_bodies(180);
    settle();

    // Zero-sized pattern
    write_dim(rlpd_pkg::CFG_IDX_WIDTH, 13'd0);
    write_dim(rlpd_pkg::CFG_IDX_HEIGHT, 13'd0);
    queue_random_bodies(30);
    settle();

    // Largest sizes: width far above the clamp, height at the clamp
    send_idle_pct = 47;
    recv_stall_pct = 26;
    write_dim(rlpd_pkg::CFG_IDX_WIDTH, 13'h1FFF);
    write_dim(rlpd_pkg::CFG_IDX_HEIGHT, rlpd_pkg::MAX_DIM);
    queue_random_bodies(150);
    settle();

    write_dim(rlpd_pkg::CFG_IDX_WIDTH, 13'd1);
    write_dim(rlpd_pkg::CFG_IDX_HEIGHT, 13'h1FFF);
    queue_random_bodies(40);
    settle();

    // Small random sizes at full rate
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_dim(rlpd_pkg::CFG_IDX_WIDTH, 13'($urandom_range(2, 40)));
    write_dim(rlpd_pkg::CFG_IDX_HEIGHT, 13'($urandom_range(2, 40)));
    queue_random_bodies(200);
    settle();

    if (fault_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Drop the run if it hangs
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
sv/rlpd_pkg.sv
sv/rlpd_core.sv
sv/rle_life_pattern_decoder_unit.sv
tb/tb_top.sv
